/* rtl/llne_pkg.sv */
// shared widths, constants and types of the lat/lon to local north/east projection
`timescale 1ns / 1ps
`default_nettype none

package llne_pkg;

  // field widths
  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int RAD_W = 31;
  localparam int COS_W = 31;
  localparam int OUT_W = 40;

  // stream and register port widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 3 * OUT_W;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_REF_LAT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REF_LON     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REF_RADIUS  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_REF_COS_LAT = 2'd3;

  localparam logic [LAT_W-1:0] REF_LAT_RST     = '0;
  localparam logic [LON_W-1:0] REF_LON_RST     = '0;
  localparam logic [RAD_W-1:0] REF_RADIUS_RST  = 31'd1632803072;
  localparam logic [COS_W-1:0] REF_COS_LAT_RST = 31'd1073741824;

  // differences and magnitudes
  localparam int DLAT_W = LAT_W + 1;
  localparam int DLON_W = LON_W + 1;
  localparam int A_W    = DLAT_W + RAD_W;
  localparam int B_W    = DLON_W + RAD_W;
  localparam int HALF_W = 32;

  // (1e-7 deg) * (m * 256) to mm, scaled by 2^64
  localparam int KQ_W  = 37;
  localparam int KQH_W = KQ_W - HALF_W;
  localparam logic [KQ_W-1:0]   KQ    = 37'd125764226703;
  localparam logic [HALF_W-1:0] KQ_LO = KQ[HALF_W-1:0];
  localparam logic [KQH_W-1:0]  KQ_HI = KQ[KQ_W-1:HALF_W];

  // cosine-scaled factor
  localparam int COS_FRAC = 30;
  localparam int FCPL_W   = COS_W + HALF_W;
  localparam int FCPH_W   = COS_W + KQH_W;
  localparam int FCP_W    = COS_W + KQ_W;
  localparam int FC_W     = FCP_W - COS_FRAC;
  localparam int FCH_W    = FC_W - HALF_W;
  localparam logic [FCPL_W-1:0] FCPL_RST = FCPL_W'(REF_COS_LAT_RST) * FCPL_W'(KQ_LO);
  localparam logic [FCPH_W-1:0] FCPH_RST = FCPH_W'(REF_COS_LAT_RST) * FCPH_W'(KQ_HI);
  localparam logic [FC_W-1:0]   FC_RST   = FC_W'(KQ);

  // north partial products
  localparam int AH_W  = A_W - HALF_W;
  localparam int NLL_W = 2 * HALF_W;
  localparam int NLH_W = HALF_W + KQH_W;
  localparam int NHL_W = AH_W + HALF_W;
  localparam int NHH_W = AH_W + KQH_W;
  localparam int PN_W  = A_W + KQ_W;

  // east partial products
  localparam int BH_W  = B_W - HALF_W;
  localparam int ELL_W = 2 * HALF_W;
  localparam int ELH_W = HALF_W + FCH_W;
  localparam int EHL_W = BH_W + HALF_W;
  localparam int EHH_W = BH_W + FCH_W;
  localparam int PE_W  = B_W + FC_W;
  localparam int RND_POS = 63;

  // rounded magnitudes; bounded well below these widths for any input
  localparam int N_W  = PN_W - 64;
  localparam int E_W  = PE_W - 64;
  localparam int NH_W = N_W - HALF_W;
  localparam int EH_W = E_W - HALF_W;

  // squares and root
  localparam int SNLL_W = 2 * HALF_W;
  localparam int SNLH_W = HALF_W + NH_W;
  localparam int SNHH_W = 2 * NH_W;
  localparam int SELL_W = 2 * HALF_W;
  localparam int SELH_W = HALF_W + EH_W;
  localparam int SEHH_W = 2 * EH_W;
  localparam int S_W    = 2 * E_W;
  localparam int R_W    = 38;
  localparam int T_W    = S_W + 2;

  typedef struct packed {
    logic [OUT_W-1:0] north;
    logic [OUT_W-1:0] east;
  } llne_side_t;

endpackage

`default_nettype wire

/* rtl/llne_dist.sv */
// pipelined squares, sum and rounded square root for the planar distance
`timescale 1ns / 1ps
`default_nettype none

module llne_dist (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [llne_pkg::N_W-1:0] nmag_i,
  input  logic [llne_pkg::E_W-1:0] emag_i,
  input  llne_pkg::llne_side_t   side_i,
  output logic                   valid_o,
  output logic [llne_pkg::OUT_W-1:0] dist_o,
  output llne_pkg::llne_side_t   side_o
);
  import llne_pkg::*;

  typedef struct packed {
    logic [S_W-1:0] rem;
    logic [R_W-1:0] root;
  } sq_step_t;

  // one restoring root bit: keeps rem = s - root^2
  function automatic sq_step_t sqrt_step(input logic [S_W-1:0] rem,
                                         input logic [R_W-1:0] root,
                                         input int unsigned b);
    logic [T_W-1:0] trial;
    sq_step_t r;
    trial = (T_W'(root) << (b + 1)) + (T_W'(1) << (2 * b));
    r.rem  = rem;
    r.root = root;
    if (trial <= T_W'(rem)) begin
      r.rem  = S_W'(T_W'(rem) - trial);
      r.root = root | (R_W'(1) << b);
    end
    return r;
  endfunction

  // square partial products
  logic              d1_v_q;
  logic [SNLL_W-1:0] d1_nll_q;
  logic [SNLH_W-1:0] d1_nlh_q;
  logic [SNHH_W-1:0] d1_nhh_q;
  logic [SELL_W-1:0] d1_ell_q;
  logic [SELH_W-1:0] d1_elh_q;
  logic [SEHH_W-1:0] d1_ehh_q;
  llne_side_t        d1_side_q;

  // squares
  logic              d2_v_q;
  logic [S_W-1:0]    d2_n2_q;
  logic [S_W-1:0]    d2_e2_q;
  llne_side_t        d2_side_q;

  // root stages, index 0 holds the sum
  logic              sq_v_q    [R_W+1];
  logic [S_W-1:0]    sq_rem_q  [R_W+1];
  logic [R_W-1:0]    sq_root_q [R_W+1];
  llne_side_t        sq_side_q [R_W+1];

  logic              rd_v_q;
  logic [OUT_W-1:0]  rd_dist_q;
  llne_side_t        rd_side_q;

  logic [HALF_W-1:0] nl, el;
  logic [NH_W-1:0]   nh;
  logic [EH_W-1:0]   eh;
  logic [R_W:0]      dist_rnd;

  assign nl = nmag_i[HALF_W-1:0];
  assign nh = nmag_i[N_W-1:HALF_W];
  assign el = emag_i[HALF_W-1:0];
  assign eh = emag_i[E_W-1:HALF_W];

  // round half up: s > r^2 + r
  assign dist_rnd = (sq_rem_q[R_W] > S_W'(sq_root_q[R_W])) ?
                    (R_W + 1)'(sq_root_q[R_W]) + (R_W + 1)'(1) :
                    (R_W + 1)'(sq_root_q[R_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_v_q <= 1'b0;
      d2_v_q <= 1'b0;
      rd_v_q <= 1'b0;
      for (int k = 0; k <= R_W; k++) begin
        sq_v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      d1_v_q    <= valid_i;
      d2_v_q    <= d1_v_q;
      sq_v_q[0] <= d2_v_q;
      for (int k = 0; k < R_W; k++) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
      rd_v_q <= sq_v_q[R_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_nll_q  <= SNLL_W'(nl) * SNLL_W'(nl);
      d1_nlh_q  <= SNLH_W'(nl) * SNLH_W'(nh);
      d1_nhh_q  <= SNHH_W'(nh) * SNHH_W'(nh);
      d1_ell_q  <= SELL_W'(el) * SELL_W'(el);
      d1_elh_q  <= SELH_W'(el) * SELH_W'(eh);
      d1_ehh_q  <= SEHH_W'(eh) * SEHH_W'(eh);
      d1_side_q <= side_i;

      // cross terms appear twice, hence the shift by 33
      d2_n2_q <= S_W'(d1_nll_q) + (S_W'(d1_nlh_q) << (HALF_W + 1))
               + (S_W'(d1_nhh_q) << (2 * HALF_W));
      d2_e2_q <= S_W'(d1_ell_q) + (S_W'(d1_elh_q) << (HALF_W + 1))
               + (S_W'(d1_ehh_q) << (2 * HALF_W));
      d2_side_q <= d1_side_q;

      sq_rem_q[0]  <= d2_n2_q + d2_e2_q;
      sq_root_q[0] <= '0;
      sq_side_q[0] <= d2_side_q;
      for (int k = 0; k < R_W; k++) begin
        {sq_rem_q[k+1], sq_root_q[k+1]} <=
          sqrt_step(sq_rem_q[k], sq_root_q[k], R_W - 1 - k);
        sq_side_q[k+1] <= sq_side_q[k];
      end

      rd_dist_q <= OUT_W'(dist_rnd);
      rd_side_q <= sq_side_q[R_W];
    end
  end

  assign valid_o = rd_v_q;
  assign dist_o  = rd_dist_q;
  assign side_o  = rd_side_q;

  // floor root leaves a remainder of at most 2r
  a_root_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v_q[R_W] |-> (sq_rem_q[R_W] <= (S_W'(sq_root_q[R_W]) << 1)))
    else $error("root remainder out of bound");

endmodule

`default_nettype wire

/* rtl/latlon_to_local_ne_distance_top.sv */
// top level: register port, projection pipeline, distance unit and output skid stage
`timescale 1ns / 1ps
`default_nettype none

// Projects a target latitude/longitude (1e-7 degree) onto a flat north/east plane
// around the reference point held in the registers, and gives north, east and the
// rounded planar distance in millimetres. One transaction is taken every clock cycle
// while the skid stage is empty; a result passes through the pipeline stages in order:
// six projection stages (input, difference, radius product, split constant product,
// sum, rounding), three square stages, one stage per bit of the 38-bit square root,
// a rounding stage and the output register. A held output stalls the whole pipeline
// through a one-entry skid stage, so s_axis_tready does not depend on m_axis_tready
// combinationally. The cosine factor is derived from the cosine register through the
// registered split products and then the registered rounded factor. Registers lie
// at byte addresses 0x0 reference latitude, 0x4 reference longitude, 0x8 radius, 0xC
// cosine of the reference latitude; the low address bits are ignored and writes must
// only happen while no transaction is in flight.

module latlon_to_local_ne_distance_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [llne_pkg::PADDR_W-1:0]         paddr,
  input  logic [llne_pkg::PDATA_W-1:0]         pwdata,
  output logic [llne_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // lat [30:0], lon [62:31], zero [63]
  input  logic [llne_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // north_mm [39:0], east_mm [79:40], distance_mm [119:80]
  output logic [llne_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import llne_pkg::*;

  // registers
  logic [LAT_W-1:0]  ref_lat_q;
  logic [LON_W-1:0]  ref_lon_q;
  logic [RAD_W-1:0]  ref_radius_q;
  logic [COS_W-1:0]  ref_cos_lat_q;
  logic              cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  // cosine factor
  logic [FCPL_W-1:0] fcp_lo_q;
  logic [FCPH_W-1:0] fcp_hi_q;
  logic [FC_W-1:0]   fc_q;
  logic [FCP_W-1:0]  fcp_sum;

  logic              en;

  // s1: input
  logic              s1_v_q;
  logic [LAT_W-1:0]  s1_lat_q;
  logic [LON_W-1:0]  s1_lon_q;

  // s2: magnitudes of the differences
  logic              s2_v_q;
  logic              s2_nneg_q, s2_eneg_q;
  logic [DLAT_W-1:0] s2_dlat_q;
  logic [DLON_W-1:0] s2_dlon_q;
  logic [DLAT_W-1:0] dlat, dlat_mag;
  logic [DLON_W-1:0] dlon, dlon_mag;

  // s3: radius products
  logic              s3_v_q;
  logic              s3_nneg_q, s3_eneg_q;
  logic [A_W-1:0]    s3_a_q;
  logic [B_W-1:0]    s3_b_q;

  // s4: partial products
  logic              s4_v_q;
  logic              s4_nneg_q, s4_eneg_q;
  logic [NLL_W-1:0]  s4_nll_q;
  logic [NLH_W-1:0]  s4_nlh_q;
  logic [NHL_W-1:0]  s4_nhl_q;
  logic [NHH_W-1:0]  s4_nhh_q;
  logic [ELL_W-1:0]  s4_ell_q;
  logic [ELH_W-1:0]  s4_elh_q;
  logic [EHL_W-1:0]  s4_ehl_q;
  logic [EHH_W-1:0]  s4_ehh_q;

  // s5: upper product bits, from the rounding bit up
  logic              s5_v_q;
  logic              s5_nneg_q, s5_eneg_q;
  logic [PN_W-1:0]   nsum;
  logic [PE_W-1:0]   esum;
  logic [PN_W-RND_POS-1:0] s5_nsum_q;
  logic [PE_W-RND_POS-1:0] s5_esum_q;

  // s6: rounded magnitudes and signed offsets
  logic              s6_v_q;
  logic [N_W-1:0]    s6_nmag_q;
  logic [E_W-1:0]    s6_emag_q;
  llne_side_t        s6_side_q;
  logic [N_W-1:0]    nmag;
  logic [E_W-1:0]    emag;

  // distance unit and output
  logic              dv;
  logic [OUT_W-1:0]  dist_mm;
  llne_side_t        dside;
  logic [OUT_TDATA_W-1:0] res_data;

  logic              out_v_q, out_v_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic              skid_v_q, skid_v_d;
  logic [OUT_TDATA_W-1:0] skid_data_q, skid_data_d;
  logic              take;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q     <= REF_LAT_RST;
      ref_lon_q     <= REF_LON_RST;
      ref_radius_q  <= REF_RADIUS_RST;
      ref_cos_lat_q <= REF_COS_LAT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_REF_LAT:     ref_lat_q     <= pwdata[LAT_W-1:0];
        REG_REF_LON:     ref_lon_q     <= pwdata[LON_W-1:0];
        REG_REF_RADIUS:  ref_radius_q  <= pwdata[RAD_W-1:0];
        REG_REF_COS_LAT: ref_cos_lat_q <= pwdata[COS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_REF_LAT:     prdata = PDATA_W'(ref_lat_q);
      REG_REF_LON:     prdata = PDATA_W'(ref_lon_q);
      REG_REF_RADIUS:  prdata = PDATA_W'(ref_radius_q);
      REG_REF_COS_LAT: prdata = PDATA_W'(ref_cos_lat_q);
      default:         prdata = '0;
    endcase
  end

  // fc = round(cos * KQ / 2^30), settles through the registered split products after a write
  assign fcp_sum = FCP_W'(fcp_lo_q) + (FCP_W'(fcp_hi_q) << HALF_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcp_lo_q <= FCPL_RST;
      fcp_hi_q <= FCPH_RST;
      fc_q     <= FC_RST;
    end else begin
      fcp_lo_q <= FCPL_W'(ref_cos_lat_q) * FCPL_W'(KQ_LO);
      fcp_hi_q <= FCPH_W'(ref_cos_lat_q) * FCPH_W'(KQ_HI);
      fc_q     <= fcp_sum[FCP_W-1:COS_FRAC] + FC_W'(fcp_sum[COS_FRAC-1]);
    end
  end

  // whole pipeline moves unless the skid stage holds a result
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  assign dlat     = {s1_lat_q[LAT_W-1], s1_lat_q} - {ref_lat_q[LAT_W-1], ref_lat_q};
  assign dlon     = {s1_lon_q[LON_W-1], s1_lon_q} - {ref_lon_q[LON_W-1], ref_lon_q};
  assign dlat_mag = dlat[DLAT_W-1] ? DLAT_W'(-dlat) : dlat;
  assign dlon_mag = dlon[DLON_W-1] ? DLON_W'(-dlon) : dlon;

  assign nsum = PN_W'(s4_nll_q) + (PN_W'(s4_nlh_q) << HALF_W)
              + (PN_W'(s4_nhl_q) << HALF_W) + (PN_W'(s4_nhh_q) << (2 * HALF_W));
  assign esum = PE_W'(s4_ell_q) + (PE_W'(s4_elh_q) << HALF_W)
              + (PE_W'(s4_ehl_q) << HALF_W) + (PE_W'(s4_ehh_q) << (2 * HALF_W));

  // half rounds away from zero: round the magnitude, then apply the sign
  assign nmag = s5_nsum_q[PN_W-RND_POS-1:1] + N_W'(s5_nsum_q[0]);
  assign emag = s5_esum_q[PE_W-RND_POS-1:1] + E_W'(s5_esum_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_lat_q <= s_axis_tdata[LAT_W-1:0];
      s1_lon_q <= s_axis_tdata[LAT_W +: LON_W];

      s2_nneg_q <= dlat[DLAT_W-1];
      s2_eneg_q <= dlon[DLON_W-1];
      s2_dlat_q <= dlat_mag;
      s2_dlon_q <= dlon_mag;

      s3_nneg_q <= s2_nneg_q;
      s3_eneg_q <= s2_eneg_q;
      s3_a_q    <= A_W'(s2_dlat_q) * A_W'(ref_radius_q);
      s3_b_q    <= B_W'(s2_dlon_q) * B_W'(ref_radius_q);

      s4_nneg_q <= s3_nneg_q;
      s4_eneg_q <= s3_eneg_q;
      s4_nll_q  <= NLL_W'(s3_a_q[HALF_W-1:0]) * NLL_W'(KQ_LO);
      s4_nlh_q  <= NLH_W'(s3_a_q[HALF_W-1:0]) * NLH_W'(KQ_HI);
      s4_nhl_q  <= NHL_W'(s3_a_q[A_W-1:HALF_W]) * NHL_W'(KQ_LO);
      s4_nhh_q  <= NHH_W'(s3_a_q[A_W-1:HALF_W]) * NHH_W'(KQ_HI);
      s4_ell_q  <= ELL_W'(s3_b_q[HALF_W-1:0]) * ELL_W'(fc_q[HALF_W-1:0]);
      s4_elh_q  <= ELH_W'(s3_b_q[HALF_W-1:0]) * ELH_W'(fc_q[FC_W-1:HALF_W]);
      s4_ehl_q  <= EHL_W'(s3_b_q[B_W-1:HALF_W]) * EHL_W'(fc_q[HALF_W-1:0]);
      s4_ehh_q  <= EHH_W'(s3_b_q[B_W-1:HALF_W]) * EHH_W'(fc_q[FC_W-1:HALF_W]);

      s5_nneg_q <= s4_nneg_q;
      s5_eneg_q <= s4_eneg_q;
      s5_nsum_q <= nsum[PN_W-1:RND_POS];
      s5_esum_q <= esum[PE_W-1:RND_POS];

      // magnitudes stay far inside the output range, so no clamp is needed
      s6_nmag_q       <= nmag;
      s6_emag_q       <= emag;
      s6_side_q.north <= s5_nneg_q ? OUT_W'(-OUT_W'(nmag)) : OUT_W'(nmag);
      s6_side_q.east  <= s5_eneg_q ? OUT_W'(-OUT_W'(emag)) : OUT_W'(emag);
    end
  end

  llne_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_v_q),
    .nmag_i  (s6_nmag_q),
    .emag_i  (s6_emag_q),
    .side_i  (s6_side_q),
    .valid_o (dv),
    .dist_o  (dist_mm),
    .side_o  (dside)
  );

  assign res_data = {dist_mm, dside.east, dside.north};
  assign take     = out_v_q && m_axis_tready;

  always_comb begin
    out_v_d     = out_v_q;
    out_data_d  = out_data_q;
    skid_v_d    = skid_v_q;
    skid_data_d = skid_data_q;
    if (skid_v_q) begin
      if (take) begin
        out_data_d = skid_data_q;
        skid_v_d   = 1'b0;
      end
    end else begin
      if (take) begin
        out_v_d = 1'b0;
      end
      if (dv) begin
        if (out_v_q && !m_axis_tready) begin
          skid_v_d    = 1'b1;
          skid_data_d = res_data;
        end else begin
          out_v_d    = 1'b1;
          out_data_d = res_data;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // magnitudes of the outgoing offsets, for the distance checks
  logic [OUT_W-1:0] chk_north, chk_east, chk_north_abs, chk_east_abs, chk_dist;

  assign chk_north     = out_data_q[OUT_W-1:0];
  assign chk_east      = out_data_q[2*OUT_W-1:OUT_W];
  assign chk_dist      = out_data_q[3*OUT_W-1:2*OUT_W];
  assign chk_north_abs = chk_north[OUT_W-1] ? OUT_W'(-chk_north) : chk_north;
  assign chk_east_abs  = chk_east[OUT_W-1] ? OUT_W'(-chk_east) : chk_east;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage holds a result while the output is empty");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid stage filled without a held output");

  a_dist_ge_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (chk_dist >= chk_north_abs) && (chk_dist >= chk_east_abs))
    else $error("distance below an offset magnitude");

endmodule

`default_nettype wire
